// ===== sv/cau_pkg.sv =====
`timescale 1ns / 1ps
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DIV_W     = PROD_W + DATA_W;
    localparam int DIV_STEPS = DATA_W;
    localparam int LATENCY   = DIV_STEPS + 5;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    // one result part on its way through the divider
    // non-divide requests park their finished magnitude in rem
    typedef struct packed {
        logic [DIV_W-1:0]  rem;
        logic [DATA_W-1:0] q;
        logic              neg;
        logic              big;
    } t_lane;

    typedef struct packed {
        logic             valid;
        logic             is_div;
        logic             dz;
        logic [DIV_W-1:0] dsh;
        t_lane            re;
        t_lane            im;
    } t_div_item;

endpackage

// ===== sv/complex_arith_unit_core.sv =====
`timescale 1ns / 1ps
// Complex ALU: add, subtract, multiply, divide on signed Q16.16 operands.
// Request channel: drive i_req_type and the four operand parts with start
// high; the request is taken at any edge where start is high and busy is
// low. busy is always low, so a request can be issued every cycle.
// Result channel: o_valid is high for exactly one cycle with o_res_real,
// o_res_imag and o_status. Results come back in request order.
// Each request passes through one multiplier stage, one
// adder stage, one magnitude stage, one divider setup stage, 32 restoring
// divider stages (one quotient bit each) and the saturating output stage.
// Throughput is one request per cycle; all operations share the same path.
// Status: 0 ok, 1 divide by zero (result zero), 2 saturated.
// Synchronous active-low reset flushes all pipeline valid bits; requests
// in flight are dropped. The receiver cannot stall: results must be taken
// in the cycle they appear.
module complex_arith_unit_core
    import cau_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_a_real,
    input  logic signed [DATA_W-1:0] i_a_imag,
    input  logic signed [DATA_W-1:0] i_b_real,
    input  logic signed [DATA_W-1:0] i_b_imag,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_res_real,
    output logic signed [DATA_W-1:0] o_res_imag,
    output logic [1:0]               o_status
);

    assign busy = 1'b0;

    // stage 1: products and add/sub
    logic                     r1_valid;
    t_op                      r1_op;
    logic                     r1_dz;
    logic signed [PROD_W-1:0] r1_ac, r1_bd, r1_ad, r1_bc, r1_cc, r1_dd;
    logic signed [DATA_W:0]   r1_as_re, r1_as_im;

    always_ff @(posedge i_clk) begin
        r1_op    <= t_op'(i_req_type);
        r1_dz    <= (i_b_real == '0) && (i_b_imag == '0);
        r1_ac    <= i_a_real * i_b_real;
        r1_bd    <= i_a_imag * i_b_imag;
        r1_ad    <= i_a_real * i_b_imag;
        r1_bc    <= i_a_imag * i_b_real;
        r1_cc    <= i_b_real * i_b_real;
        r1_dd    <= i_b_imag * i_b_imag;
        if (i_req_type == OP_SUB) begin
            r1_as_re <= {i_a_real[DATA_W-1], i_a_real} - {i_b_real[DATA_W-1], i_b_real};
            r1_as_im <= {i_a_imag[DATA_W-1], i_a_imag} - {i_b_imag[DATA_W-1], i_b_imag};
        end else begin
            r1_as_re <= {i_a_real[DATA_W-1], i_a_real} + {i_b_real[DATA_W-1], i_b_real};
            r1_as_im <= {i_a_imag[DATA_W-1], i_a_imag} + {i_b_imag[DATA_W-1], i_b_imag};
        end
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    // stage 2: exact sums and denominator
    logic                    r2_valid;
    t_op                     r2_op;
    logic                    r2_dz;
    logic signed [SUM_W-1:0] r2_re, r2_im;
    logic [PROD_W-1:0]       r2_den;
    logic signed [SUM_W-1:0] n2_re, n2_im;
    logic signed [SUM_W-1:0] x_ac, x_bd, x_ad, x_bc;

    assign x_ac = {r1_ac[PROD_W-1], r1_ac};
    assign x_bd = {r1_bd[PROD_W-1], r1_bd};
    assign x_ad = {r1_ad[PROD_W-1], r1_ad};
    assign x_bc = {r1_bc[PROD_W-1], r1_bc};

    always_comb begin
        case (r1_op)
            OP_MUL: begin
                n2_re = x_ac - x_bd;
                n2_im = x_ad + x_bc;
            end
            OP_DIV: begin
                n2_re = x_ac + x_bd;
                n2_im = x_bc - x_ad;
            end
            default: begin
                n2_re = SUM_W'(r1_as_re);
                n2_im = SUM_W'(r1_as_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r2_op  <= r1_op;
        r2_dz  <= r1_dz;
        r2_re  <= n2_re;
        r2_im  <= n2_im;
        r2_den <= r1_cc + r1_dd;
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    // stage 3: sign and magnitude
    logic              r3_valid;
    t_op               r3_op;
    logic              r3_dz;
    logic [PROD_W-1:0] r3_den;
    logic [PROD_W-1:0] r3_re_mag, r3_im_mag;
    logic              r3_re_neg, r3_im_neg;
    logic [SUM_W-1:0]  n3_re_abs, n3_im_abs;

    assign n3_re_abs = r2_re[SUM_W-1] ? -r2_re : r2_re;
    assign n3_im_abs = r2_im[SUM_W-1] ? -r2_im : r2_im;

    always_ff @(posedge i_clk) begin
        r3_op     <= r2_op;
        r3_dz     <= r2_dz;
        r3_den    <= r2_den;
        r3_re_mag <= n3_re_abs[PROD_W-1:0];
        r3_im_mag <= n3_im_abs[PROD_W-1:0];
        r3_re_neg <= r2_re[SUM_W-1];
        r3_im_neg <= r2_im[SUM_W-1];
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    // stage 4: divider setup, scaling for multiply
    t_div_item        n4_item;
    t_div_item        div_pipe [DIV_STEPS+1];
    logic [DIV_W-1:0] den_hi;
    logic [DIV_W-1:0] re_num, im_num;

    assign den_hi = {r3_den, {DATA_W{1'b0}}};
    assign re_num = {{DATA_W{1'b0}}, r3_re_mag} << FRAC_BITS;
    assign im_num = {{DATA_W{1'b0}}, r3_im_mag} << FRAC_BITS;

    always_comb begin
        n4_item.valid  = r3_valid;
        n4_item.is_div = (r3_op == OP_DIV);
        n4_item.dz     = r3_dz && (r3_op == OP_DIV);
        n4_item.dsh    = den_hi >> 1;
        n4_item.re.q   = '0;
        n4_item.im.q   = '0;
        n4_item.re.neg = r3_re_neg;
        n4_item.im.neg = r3_im_neg;
        n4_item.re.big = 1'b0;
        n4_item.im.big = 1'b0;
        case (r3_op)
            OP_DIV: begin
                n4_item.re.rem = re_num;
                n4_item.im.rem = im_num;
                // quotient of 2^32 or more saturates either way
                n4_item.re.big = re_num >= den_hi;
                n4_item.im.big = im_num >= den_hi;
            end
            OP_MUL: begin
                n4_item.re.rem = {{DATA_W{1'b0}}, r3_re_mag >> FRAC_BITS};
                n4_item.im.rem = {{DATA_W{1'b0}}, r3_im_mag >> FRAC_BITS};
            end
            default: begin
                n4_item.re.rem = {{DATA_W{1'b0}}, r3_re_mag};
                n4_item.im.rem = {{DATA_W{1'b0}}, r3_im_mag};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_pipe[0] <= '0;
        end else begin
            div_pipe[0] <= n4_item;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        cau_div_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_item (div_pipe[g]),
            .o_item (div_pipe[g+1])
        );
    end

    // output stage: saturation and status
    t_div_item         fin;
    logic [PROD_W-1:0] re_mag, im_mag;
    logic [DATA_W-1:0] re_sat, im_sat;
    logic              re_ovf, im_ovf;

    assign fin    = div_pipe[DIV_STEPS];
    assign re_mag = fin.is_div ? {{DATA_W{1'b0}}, fin.re.q} : fin.re.rem[PROD_W-1:0];
    assign im_mag = fin.is_div ? {{DATA_W{1'b0}}, fin.im.q} : fin.im.rem[PROD_W-1:0];

    function automatic logic [DATA_W:0] sat(input logic [PROD_W-1:0] mag,
                                           input logic neg, input logic big);
        logic [DATA_W:0] r;
        logic            nz;
        nz = (mag != '0) || big;
        if (neg && nz) begin
            if (big || mag > {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}}) begin
                r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r = {1'b0, DATA_W'(-mag)};
            end
        end else begin
            if (big || mag > {{(DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}}) begin
                r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                r = {1'b0, mag[DATA_W-1:0]};
            end
        end
        return r;
    endfunction

    always_comb begin
        {re_ovf, re_sat} = sat(re_mag, fin.re.neg, fin.re.big);
        {im_ovf, im_sat} = sat(im_mag, fin.im.neg, fin.im.big);
    end

    always_ff @(posedge i_clk) begin
        if (fin.dz) begin
            o_res_real <= '0;
            o_res_imag <= '0;
            o_status   <= ST_DIVZ;
        end else begin
            o_res_real <= re_sat;
            o_res_imag <= im_sat;
            o_status   <= (re_ovf || im_ovf) ? ST_OVF : ST_OK;
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= fin.valid;
        end
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without matching request");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_DIVZ) |-> (o_res_real == '0 && o_res_imag == '0))
        else $error("divide by zero with nonzero result");

    a_no_rsvd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != ST_RSVD))
        else $error("reserved status code");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVF) |->
        (o_res_real == {1'b0, {(DATA_W-1){1'b1}}} || o_res_real == {1'b1, {(DATA_W-1){1'b0}}} ||
         o_res_imag == {1'b0, {(DATA_W-1){1'b1}}} || o_res_imag == {1'b1, {(DATA_W-1){1'b0}}}))
        else $error("overflow without saturated part");

endmodule

// ===== sv/cau_div_stage.sv =====
`timescale 1ns / 1ps
module cau_div_stage
    import cau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_item i_item,
    output t_div_item o_item
);

    t_div_item r_item;
    t_div_item n_item;

    function automatic t_lane step(input t_lane l, input logic [DIV_W-1:0] dsh);
        t_lane            r;
        logic [DIV_W:0]   trial;
        r     = l;
        trial = {1'b0, l.rem} - {1'b0, dsh};
        if (!trial[DIV_W]) begin
            r.rem = trial[DIV_W-1:0];
            r.q   = {l.q[DATA_W-2:0], 1'b1};
        end else begin
            r.q   = {l.q[DATA_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_item = i_item;
        if (i_item.is_div) begin
            n_item.re  = step(i_item.re, i_item.dsh);
            n_item.im  = step(i_item.im, i_item.dsh);
            n_item.dsh = i_item.dsh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ===== test/complex_arith_unit_core_tb.sv =====
`timescale 1ns / 1ps
module complex_arith_unit_core_tb;
    import cau_pkg::*;

    typedef struct {
        t_op         op;
        logic [31:0] ar, ai, br, bi;
    } t_request;

    typedef struct {
        logic [31:0] re, im;
        logic [1:0]  st;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = '0;
    logic signed [31:0] i_a_real = '0, i_a_imag = '0, i_b_real = '0, i_b_imag = '0;
    logic        o_valid;
    logic signed [31:0] o_res_real, o_res_imag;
    logic [1:0]  o_status;

    t_request pending_q[$];
    t_answer  answer_q[$];
    int       errors = 0;
    int       results_seen = 0;
    int       op_count[4] = '{0, 0, 0, 0};
    int       ovf_seen = 0, divz_seen = 0;
    longint   cycles = 0;
    bit       calm = 1'b0;
    bit       hold = 1'b0;
    bit       stim_done = 1'b0;

    complex_arith_unit_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag), .o_valid(o_valid),
        .o_res_real(o_res_real), .o_res_imag(o_res_imag), .o_status(o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // saturate an exact value to 32 bits, flag overflow
    function automatic logic [31:0] clamp32(logic signed [127:0] v, ref bit ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // truncating division toward zero
    function automatic logic signed [127:0] div_trunc(logic signed [127:0] n,
                                                      logic signed [127:0] d);
        logic signed [127:0] q;
        q = (n < 0 ? -n : n) / d;
        return n < 0 ? -q : q;
    endfunction

    function automatic t_answer complex_result(t_request r);
        t_answer a;
        logic signed [127:0] xa, xb, xc, xd, re, im, den;
        bit ovf;
        ovf = 1'b0;
        xa = $signed(r.ar); xb = $signed(r.ai);
        xc = $signed(r.br); xd = $signed(r.bi);
        case (r.op)
            OP_ADD: begin re = xa + xc; im = xb + xd; end
            OP_SUB: begin re = xa - xc; im = xb - xd; end
            OP_MUL: begin
                re = div_trunc(xa * xc - xb * xd, 128'sd1 <<< FRAC_BITS);
                im = div_trunc(xa * xd + xb * xc, 128'sd1 <<< FRAC_BITS);
            end
            default: begin
                if (xc == 0 && xd == 0) begin
                    a.re = '0; a.im = '0; a.st = ST_DIVZ;
                    return a;
                end
                den = xc * xc + xd * xd;
                re = div_trunc((xa * xc + xb * xd) <<< FRAC_BITS, den);
                im = div_trunc((xb * xc - xa * xd) <<< FRAC_BITS, den);
            end
        endcase
        a.re = clamp32(re, ovf);
        a.im = clamp32(im, ovf);
        a.st = ovf ? ST_OVF : ST_OK;
        return a;
    endfunction

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4: return $signed($urandom_range(0, 1023)) - 512;
            5: return $signed($urandom_range(0, 32'h7ffff)) - 32'h40000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push(t_op op, logic [31:0] ar, ai, br, bi);
        t_request r;
        r.op = op; r.ar = ar; r.ai = ai; r.br = br; r.bi = bi;
        pending_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // request still waiting
        end else if (pending_q.size() != 0 && !hold && (calm || $urandom_range(0, 99) >= 21)) begin
            r = pending_q.pop_front();
            answer_q.push_back(complex_result(r));
            op_count[r.op]++;
            start <= 1'b1;
            i_req_type <= r.op;
            i_a_real <= r.ar; i_a_imag <= r.ai; i_b_real <= r.br; i_b_imag <= r.bi;
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer w;
        cycles++;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (answer_q.size() == 0) begin
                errors++;
                $display("unexpected result %h %h %0d", o_res_real, o_res_imag, o_status);
            end else begin
                w = answer_q.pop_front();
                if (o_res_real !== w.re) report_mismatch("res_real", o_res_real, w.re);
                if (o_res_imag !== w.im) report_mismatch("res_imag", o_res_imag, w.im);
                if (o_status !== w.st) report_mismatch("status", o_status, w.st);
                if (w.st == ST_OVF) ovf_seen++;
                if (w.st == ST_DIVZ) divz_seen++;
            end
        end
        if (cycles > 200000) begin
            $display("timeout with %0d results outstanding", answer_q.size());
            $display("complex_arith_unit_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [31:0] m;
        // directed: extremes, every operation, divide by zero, saturation
        m = 32'h80000000;
        push(OP_ADD, 32'h7fffffff, m, 32'h7fffffff, m);
        push(OP_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00008000);
        push(OP_SUB, m, 32'h7fffffff, 32'h7fffffff, m);
        push(OP_SUB, 32'h00030000, 0, 32'h00010000, 32'h00010000);
        push(OP_MUL, m, m, m, m);
        push(OP_MUL, 32'h7fffffff, m, 32'h7fffffff, 32'h7fffffff);
        push(OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hfffb0000);
        push(OP_MUL, 32'hffffffff, 0, 32'h00000001, 0);
        push(OP_MUL, 0, 0, 0, 0);
        push(OP_DIV, 32'h00010000, 32'h00010000, 0, 0);
        push(OP_DIV, 0, 0, 0, 0);
        push(OP_DIV, m, m, 0, 0);
        push(OP_DIV, 32'h00010000, 0, 32'h00020000, 0);
        push(OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h00000001, 0);
        push(OP_DIV, m, m, m, m);
        push(OP_DIV, m, 0, m, 0);
        push(OP_DIV, 32'h00050000, 32'hfffe0000, 32'h00010000, 32'h00020000);
        push(OP_DIV, 32'hffffffff, 0, 32'h7fffffff, 32'h7fffffff);
        push(OP_DIV, 32'h00000001, 32'h00000001, 0, 32'hffffffff);
        push(OP_DIV, 32'h7fffffff, 0, 0, 32'h7fffffff);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_q.size() != 0) @(posedge i_clk);
        // drain fully before the random part
        hold <= 1'b1;
        while (answer_q.size() != 0) @(posedge i_clk);
        hold <= 1'b0;
        for (int k = 0; k < 1930; k++) begin
            t_op op;
            op = t_op'($urandom_range(0, 3));
            push(op, rand_part(), rand_part(), rand_part(), rand_part());
            if (k == 600) calm = 1'b1;
            if (k == 900) calm = 1'b0;
            if (pending_q.size() > 8) @(posedge i_clk);
            while (pending_q.size() > 16) @(posedge i_clk);
        end
        while (pending_q.size() != 0) @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("requests add/sub/mul/div: %0d/%0d/%0d/%0d, results %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
        $display("saturated results %0d, divide-by-zero results %0d", ovf_seen, divz_seen);
        if (errors == 0 && answer_q.size() == 0)
            $display("complex_arith_unit_core_tb OK");
        else
            $display("complex_arith_unit_core_tb NOT OK");
        $finish;
    end
endmodule

// ===== complex_arith_unit_core.f =====
sv/cau_pkg.sv
sv/cau_div_stage.sv
sv/complex_arith_unit_core.sv
test/complex_arith_unit_core_tb.sv
